// File: src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit arena allocator: field widths,
// mode and status codes, the chunk table entry and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned SIZE_W   = 23;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned TOTAL_W  = 24;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SIZE_W-1:0] ARENA_CAPACITY_RESET = 23'd65536;

  localparam logic [0:0] REG_ARENA_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    MODE_FIND    = 2'd0,
    MODE_CREATE  = 2'd1,
    MODE_FIT     = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FIT     = 2'd1,
    STATUS_ARENA_FULL = 2'd2,
    STATUS_TABLE_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic                used;
    logic [OFFSET_W-1:0] start;
    logic [SIZE_W-1:0]   capacity;
  } entry_t;

endpackage

`default_nettype wire

// File: src/bfa_req_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel of the allocator: valid/ready handshake with mode, size
// and the mark-used flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_req_if;

  logic                         valid;
  logic                         ready;
  bfa_pkg::mode_e               mode;
  logic [bfa_pkg::SIZE_W-1:0]   requested_size;
  logic                         mark_used;

  modport source (output valid, output mode, output requested_size, output mark_used,
                  input ready);
  modport sink (input valid, input mode, input requested_size, input mark_used,
                output ready);

endinterface

`default_nettype wire

// File: src/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel of the allocator: valid/ready handshake with status,
// chunk description, remaining space and the fit flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_rsp_if;

  logic                           valid;
  logic                           ready;
  bfa_pkg::status_e               status;
  logic [bfa_pkg::INDEX_W-1:0]    chunk_index;
  logic [bfa_pkg::OFFSET_W-1:0]   chunk_offset;
  logic [bfa_pkg::SIZE_W-1:0]     chunk_size;
  logic [bfa_pkg::SIZE_W-1:0]     space_left;
  logic                           fits;

  modport source (output valid, output status, output chunk_index, output chunk_offset,
                  output chunk_size, output space_left, output fits, input ready);
  modport sink (input valid, input status, input chunk_index, input chunk_offset,
                input chunk_size, input space_left, input fits, output ready);

endinterface

`default_nettype wire

// File: src/bfa_chunk_mem.sv
// ----------------------------------------------------------------------------
// bfa_chunk_mem
// Chunk table storage: one write port and one read port; read data is
// registered and appears in the cycle after the read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_chunk_mem #(
  parameter int unsigned  DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output bfa_pkg::entry_t      rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  bfa_pkg::entry_t      wr_data_i
);

  bfa_pkg::entry_t mem_q [DEPTH];
  bfa_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/bfa_align_unit.sv
// ----------------------------------------------------------------------------
// bfa_align_unit
// Computes the aligned chunk total, size plus header rounded up to the
// alignment, in a three-stage pipeline built on a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_align_unit #(
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned ALIGN_BYTES  = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [bfa_pkg::SIZE_W-1:0]   size_i,
  output logic                              done_o,
  output logic [bfa_pkg::TOTAL_W-1:0]       total_o
);

  localparam int unsigned     TW    = bfa_pkg::TOTAL_W;
  localparam int unsigned     SHIFT = TW + $clog2(ALIGN_BYTES);
  localparam int unsigned     MW    = TW + 2;
  localparam int unsigned     PW    = TW + MW;
  localparam longint unsigned ONE   = 64'd1;
  localparam longint unsigned RECIP = ((ONE << SHIFT) + 64'(ALIGN_BYTES) - ONE) /
                                      64'(ALIGN_BYTES);
  localparam logic [MW-1:0]   RECIP_C = MW'(RECIP);

  logic          stage1_q;
  logic          stage2_q;
  logic          done_q;
  logic [TW-1:0] biased_q;
  logic [TW-1:0] quot_q;
  logic [TW-1:0] total_q;

  logic [PW-1:0] prod;
  logic [TW-1:0] quot;

  always_comb begin
    prod = PW'(biased_q) * PW'(RECIP_C);
    quot = TW'(prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
      done_q   <= 1'b0;
      biased_q <= '0;
      quot_q   <= '0;
      total_q  <= '0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
      if (start_i) begin
        biased_q <= TW'(size_i) + TW'(HEADER_BYTES + ALIGN_BYTES - 1);
      end
      if (stage1_q) begin
        quot_q <= quot;
      end
      if (stage2_q) begin
        total_q <= TW'(quot_q * TW'(ALIGN_BYTES));
      end
      if (start_i) begin
        done_q <= 1'b0;
      end else if (stage2_q) begin
        done_q <= 1'b1;
      end
    end
  end

  assign done_o  = done_q;
  assign total_o = total_q;

endmodule

`default_nettype wire

// File: src/best_fit_arena_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_arena_allocator_unit
// Best-fit allocator with a bump arena over an indexed chunk table held in a
// synchronous memory, with an APB-style port for the arena capacity.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   req      in         valid/ready            mode, requested_size, mark_used
//   rsp      out        valid/ready            status, chunk, space_left, fits
//   apb      in/out     psel/penable, pready   arena_capacity at byte address 0
//
// A find transaction waits both for the table scan, which reads the entries in
// turn through the single memory read port, and for the three-stage alignment
// pipeline; other modes, and a find over an empty table, wait only for the
// alignment pipeline. The unit turns idle and can accept the next request in
// the same cycle that the registered response becomes valid.
// Reset clears the table count, offset and release flag; no clearing pass runs.
// One transaction is in work at a time; a finished result waits in the output
// register while the next request is accepted, and that one stalls before its
// commit until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_arena_allocator_unit #(
  parameter int unsigned MAX_CHUNKS   = 64,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned ALIGN_BYTES  = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  bfa_req_if.sink                               req,
  bfa_rsp_if.source                             rsp,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [bfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bfa_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SW    = bfa_pkg::SIZE_W;
  localparam int unsigned OW    = bfa_pkg::OFFSET_W;
  localparam int unsigned XW    = bfa_pkg::INDEX_W;
  localparam int unsigned TW    = bfa_pkg::TOTAL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [SW-1:0]    arena_q;
  logic [CNT_W-1:0] count_q;
  logic [SW-1:0]    offset_q;
  logic             released_q;

  bfa_pkg::mode_e   mode_q;
  logic [SW-1:0]    size_q;
  logic             mark_q;
  logic [SW-1:0]    rem_q;

  logic [CNT_W-1:0] scan_addr_q;
  logic             data_vld_q;
  logic [IDX_W-1:0] data_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [SW-1:0]    best_cap_q;
  logic [OW-1:0]    best_start_q;

  logic             rsp_valid_q;
  bfa_pkg::status_e rsp_status_q;
  logic [XW-1:0]    rsp_index_q;
  logic [OW-1:0]    rsp_offset_q;
  logic [SW-1:0]    rsp_size_q;
  logic [SW-1:0]    rsp_space_q;
  logic             rsp_fits_q;

  logic             accept;
  logic             out_free;
  logic             commit_go;
  logic [SW-1:0]    remaining;
  logic             scan_issue;
  logic             cand;
  logic             better;
  logic             create_ok;
  logic             arena_short;
  logic [TW-1:0]    total;
  logic             align_done;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  bfa_pkg::entry_t  mem_wr_data;
  bfa_pkg::entry_t  mem_rd_data;
  logic [IDX_W+XW-1:0] best_idx_ext;
  logic [IDX_W+XW-1:0] new_idx_ext;
  logic             cfg_hit;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == bfa_pkg::REG_ARENA_CAPACITY);
  assign prdata  = cfg_hit ? bfa_pkg::APB_DATA_W'(arena_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= bfa_pkg::ARENA_CAPACITY_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      arena_q <= pwdata[SW-1:0];
    end
  end

  bfa_align_unit #(
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .size_i  (req.requested_size),
    .done_o  (align_done),
    .total_o (total)
  );

  bfa_chunk_mem #(
    .DEPTH (MAX_CHUNKS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (scan_issue),
    .rd_addr_i (scan_addr_q[IDX_W-1:0]),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  always_comb begin
    accept     = (state_q == ST_IDLE) && req.valid;
    out_free   = !rsp_valid_q || rsp.ready;
    commit_go  = (state_q == ST_COMMIT) && out_free;

    if (released_q || (offset_q >= arena_q)) begin
      remaining = '0;
    end else begin
      remaining = arena_q - offset_q;
    end

    scan_issue = (state_q == ST_BUSY) && (mode_q == bfa_pkg::MODE_FIND) &&
                 (scan_addr_q < count_q);
    cand       = !mem_rd_data.used && (mem_rd_data.capacity >= size_q);
    better     = !found_q || (mem_rd_data.capacity < best_cap_q);

    arena_short = total > TW'(rem_q);
    create_ok   = !arena_short && (count_q < CNT_W'(MAX_CHUNKS));

    best_idx_ext = {{XW{1'b0}}, best_idx_q};
    new_idx_ext  = {{XW{1'b0}}, count_q[IDX_W-1:0]};

    mem_wr_en   = 1'b0;
    mem_wr_addr = best_idx_q;
    mem_wr_data = '{used: 1'b1, start: best_start_q, capacity: best_cap_q};
    if (commit_go) begin
      if (mode_q == bfa_pkg::MODE_FIND) begin
        mem_wr_en = found_q;
      end else if (mode_q == bfa_pkg::MODE_CREATE) begin
        mem_wr_en   = create_ok;
        mem_wr_addr = count_q[IDX_W-1:0];
        mem_wr_data = '{used: mark_q, start: offset_q[OW-1:0],
                        capacity: SW'(total - TW'(HEADER_BYTES))};
      end
    end
  end

  assign req.ready        = (state_q == ST_IDLE);
  assign rsp.valid        = rsp_valid_q;
  assign rsp.status       = rsp_status_q;
  assign rsp.chunk_index  = rsp_index_q;
  assign rsp.chunk_offset = rsp_offset_q;
  assign rsp.chunk_size   = rsp_size_q;
  assign rsp.space_left   = rsp_space_q;
  assign rsp.fits         = rsp_fits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      offset_q     <= '0;
      released_q   <= 1'b0;
      mode_q       <= bfa_pkg::MODE_FIND;
      size_q       <= '0;
      mark_q       <= 1'b0;
      rem_q        <= '0;
      scan_addr_q  <= '0;
      data_vld_q   <= 1'b0;
      data_idx_q   <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_cap_q   <= '0;
      best_start_q <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= bfa_pkg::STATUS_OK;
      rsp_index_q  <= '0;
      rsp_offset_q <= '0;
      rsp_size_q   <= '0;
      rsp_space_q  <= '0;
      rsp_fits_q   <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            mode_q      <= req.mode;
            size_q      <= req.requested_size;
            mark_q      <= req.mark_used;
            rem_q       <= remaining;
            scan_addr_q <= '0;
            data_vld_q  <= 1'b0;
            found_q     <= 1'b0;
            state_q     <= ST_BUSY;
          end
        end

        ST_BUSY: begin
          data_vld_q <= scan_issue;
          if (scan_issue) begin
            scan_addr_q <= scan_addr_q + 1'b1;
            data_idx_q  <= scan_addr_q[IDX_W-1:0];
          end
          if (data_vld_q && cand && better) begin
            found_q      <= 1'b1;
            best_idx_q   <= data_idx_q;
            best_cap_q   <= mem_rd_data.capacity;
            best_start_q <= mem_rd_data.start;
          end
          if (align_done && !scan_issue && !data_vld_q) begin
            state_q <= ST_COMMIT;
          end
        end

        ST_COMMIT: begin
          if (out_free) begin
            rsp_status_q <= bfa_pkg::STATUS_OK;
            rsp_index_q  <= '0;
            rsp_offset_q <= '0;
            rsp_size_q   <= '0;
            rsp_fits_q   <= !(total > TW'(rem_q));
            case (mode_q)
              bfa_pkg::MODE_FIND: begin
                if (found_q) begin
                  rsp_index_q  <= best_idx_ext[XW-1:0];
                  rsp_offset_q <= best_start_q;
                  rsp_size_q   <= best_cap_q;
                end else begin
                  rsp_status_q <= bfa_pkg::STATUS_NO_FIT;
                end
              end
              bfa_pkg::MODE_CREATE: begin
                if (arena_short) begin
                  rsp_status_q <= bfa_pkg::STATUS_ARENA_FULL;
                end else if (!create_ok) begin
                  rsp_status_q <= bfa_pkg::STATUS_TABLE_FULL;
                end else begin
                  rsp_index_q  <= new_idx_ext[XW-1:0];
                  rsp_offset_q <= offset_q[OW-1:0];
                  rsp_size_q   <= mem_wr_data.capacity;
                  offset_q     <= offset_q + total[SW-1:0];
                  count_q      <= count_q + 1'b1;
                end
              end
              bfa_pkg::MODE_RELEASE: begin
                count_q    <= '0;
                offset_q   <= '0;
                released_q <= 1'b1;
              end
              default: begin
              end
            endcase
            state_q <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          rsp_space_q <= remaining;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best-fit arena allocator. Requests are driven
// as directed cases and then as random phases under several arena capacities.
// A scoreboard follows the chunk table, bump offset and release flag, and it
// checks every response field by field. Both channels idle at random, and the
// response side holds off once in a while so that the request side backs up.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HDR_BYTES = 32;
  localparam int unsigned ALIGN = 64;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = APB_ADDR_W'(4 * REG_ARENA_CAPACITY);

  typedef struct {
    status_e             status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   space;
    logic                fits;
  } rsp_t;

  class arena_scoreboard;
    logic [SIZE_W-1:0]   capacity_q;
    logic [SIZE_W-1:0]   slot_capacity [TABLE_DEPTH];
    logic [OFFSET_W-1:0] slot_start [TABLE_DEPTH];
    logic                slot_used [TABLE_DEPTH];
    int unsigned         slot_count;
    logic [SIZE_W-1:0]   bump;
    bit                  released;
    rsp_t                expected_results [$];
    int                  errors;
    int                  checked;
    int                  mode_seen [4];
    int                  status_seen [4];

    function new();
      capacity_q = ARENA_CAPACITY_RESET;
      slot_count = 0;
      bump = '0;
      released = 1'b0;
      errors = 0;
      checked = 0;
      foreach (mode_seen[i]) mode_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned space_now();
      if (released || bump >= capacity_q) return 0;
      return 32'(capacity_q) - 32'(bump);
    endfunction

    function void set_capacity(logic [SIZE_W-1:0] value);
      capacity_q = value;
    endfunction

    function void note_request(mode_e mode, logic [SIZE_W-1:0] size, logic mark);
      rsp_t        e;
      int unsigned total;
      int          best;
      bit          found;
      total = ((32'(size) + HDR_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
      e.status = STATUS_OK;
      e.index = '0;
      e.offset = '0;
      e.size = '0;
      e.fits = (space_now() >= total);
      case (mode)
        MODE_FIND: begin
          found = 1'b0;
          best = 0;
          for (int i = 0; i < slot_count; i++) begin
            if (!slot_used[i] && slot_capacity[i] >= size) begin
              if (!found || slot_capacity[i] < slot_capacity[best]) begin
                best = i;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            slot_used[best] = 1'b1;
            e.index = INDEX_W'(best);
            e.offset = slot_start[best];
            e.size = slot_capacity[best];
          end else begin
            e.status = STATUS_NO_FIT;
          end
        end
        MODE_CREATE: begin
          if (space_now() < total) begin
            e.status = STATUS_ARENA_FULL;
          end else if (slot_count >= TABLE_DEPTH) begin
            e.status = STATUS_TABLE_FULL;
          end else begin
            slot_capacity[slot_count] = SIZE_W'(total - HDR_BYTES);
            slot_start[slot_count] = bump[OFFSET_W-1:0];
            slot_used[slot_count] = mark;
            e.index = INDEX_W'(slot_count);
            e.offset = bump[OFFSET_W-1:0];
            e.size = slot_capacity[slot_count];
            bump = SIZE_W'(32'(bump) + total);
            slot_count++;
          end
        end
        MODE_RELEASE: begin
          slot_count = 0;
          bump = '0;
          released = 1'b1;
        end
        default: begin
        end
      endcase
      e.space = SIZE_W'(space_now());
      expected_results.push_back(e);
      mode_seen[mode]++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: response with no request pending, status %0d index %0d", $time,
                 got.status, got.index);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      status_seen[e.status]++;
      compare_field("status", e.status, got.status);
      compare_field("chunk_index", e.index, got.index);
      compare_field("chunk_offset", e.offset, got.offset);
      compare_field("chunk_size", e.size, got.size);
      compare_field("space_left", e.space, got.space);
      compare_field("fits", e.fits, got.fits);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  arena_scoreboard sb;
  int rx_style;
  int hold_asked;
  bit gaps_on;
  int burst_left;

  best_fit_arena_allocator_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin : monitor
    rsp_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.mode, req_ch.requested_size, req_ch.mark_used);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.index = rsp_ch.chunk_index;
        got.offset = rsp_ch.chunk_offset;
        got.size = rsp_ch.chunk_size;
        got.space = rsp_ch.space_left;
        got.fits = rsp_ch.fits;
        sb.check_result(got);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_done;
    int cyc;
    hold_left = 0;
    hold_done = 0;
    cyc = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_left == 0 && hold_done != hold_asked) begin
        hold_left = HOLD_CYCLES;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ((cyc % 7) < 4);
          default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic offer(input mode_e mode, input logic [SIZE_W-1:0] size, input logic mark);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.requested_size <= size;
    req_ch.mark_used <= mark;
    do @(posedge clk_i); while (!req_ch.ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAPACITY_ADDR;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic verify_capacity();
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(sb.capacity_q)) begin
      $display("%0t: arena_capacity readback mismatch, expected %0d, actual %0d", $time,
               sb.capacity_q, rd);
      sb.errors++;
    end
  endtask

  task automatic write_capacity(input logic [SIZE_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, APB_DATA_W'(value), rd);
    sb.set_capacity(value);
    verify_capacity();
  endtask

  task automatic run_phase(input int n, input logic [SIZE_W-1:0] big_max, input int style,
                           input bit gaps, input bit hold);
    int            r;
    mode_e         mode;
    logic [SIZE_W-1:0] size;
    logic          mark;
    rx_style = style;
    gaps_on = gaps;
    if (hold) hold_asked++;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      mark = ($urandom_range(0, 3) == 0);
      if (r < 4) begin
        mode = MODE_CREATE;
        size = SIZE_W'($urandom_range(0, 200));
      end else if (r < 7) begin
        mode = MODE_CREATE;
        size = SIZE_W'($urandom_range(0, big_max));
      end else if (r < 9) begin
        mode = MODE_CREATE;
        size = SIZE_W'($urandom_range(0, 4000));
      end else if (r < 52) begin
        mode = MODE_FIND;
        size = SIZE_W'($urandom_range(0, 260));
      end else if (r < 57) begin
        mode = MODE_FIND;
        size = SIZE_W'($urandom_range(0, 4194304));
      end else if (r < 80) begin
        mode = MODE_FIT;
        size = SIZE_W'($urandom_range(0, 2000));
      end else begin
        mode = MODE_FIT;
        size = SIZE_W'($urandom_range(0, 4194304));
      end
      offer(mode, size, mark);
    end
  endtask

  initial begin : main
    sb = new();
    rx_style = 2;
    hold_asked = 0;
    gaps_on = 1'b1;
    burst_left = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_FIND;
    req_ch.requested_size = '0;
    req_ch.mark_used = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    verify_capacity();
    offer(MODE_FIT, 0, 0);
    offer(MODE_FIT, 4194304, 1);
    offer(MODE_FIT, 65504, 0);
    offer(MODE_FIT, 65505, 1);
    offer(MODE_FIND, 0, 0);
    offer(MODE_CREATE, 0, 0);
    offer(MODE_CREATE, 33, 1);
    offer(MODE_CREATE, 31, 0);
    offer(MODE_CREATE, 100, 0);
    offer(MODE_FIND, 0, 1);
    offer(MODE_FIND, 32, 0);
    offer(MODE_FIND, 32, 0);
    offer(MODE_FIND, 1, 0);
    offer(MODE_CREATE, 4194304, 0);
    offer(MODE_CREATE, 65056, 0);
    offer(MODE_FIT, 0, 0);
    offer(MODE_CREATE, 0, 0);
    offer(MODE_FIND, 4194304, 0);
    offer(MODE_FIND, 65056, 0);
    offer(MODE_FIND, 65056, 0);

    quiesce();
    write_capacity(4194304);
    run_phase(250, 65536, 0, 1'b0, 1'b0);
    quiesce();
    write_capacity(0);
    run_phase(100, 4194304, 1, 1'b1, 1'b1);
    quiesce();
    write_capacity(sb.bump >> 1);
    run_phase(100, 4194304, 2, 1'b1, 1'b0);
    quiesce();
    write_capacity(SIZE_W'(sb.bump + $urandom_range(0, 3000)));
    run_phase(250, 4194304, 3, 1'b1, 1'b0);
    quiesce();
    write_capacity(4194304);
    run_phase(250, 65536, 1, 1'b1, 1'b1);
    quiesce();
    write_capacity(SIZE_W'($urandom_range(0, 4194304)));
    run_phase(250, 65536, 2, 1'b1, 1'b0);

    // Fill the table to its limit, then exercise table full and release.
    quiesce();
    write_capacity(4194304);
    rx_style = 1;
    while (sb.slot_count < TABLE_DEPTH && sb.space_now() >= ALIGN) begin
      offer(MODE_CREATE, 0, 1'($urandom_range(0, 1)));
    end
    offer(MODE_CREATE, 0, 1);
    offer(MODE_CREATE, 4194304, 0);
    offer(MODE_FIND, 0, 0);
    offer(MODE_RELEASE, SIZE_W'($urandom_range(0, 4194304)), 1'($urandom_range(0, 1)));
    offer(MODE_FIT, 0, 0);
    offer(MODE_CREATE, 0, 0);
    offer(MODE_RELEASE, 0, 1);
    offer(MODE_FIND, 0, 0);
    quiesce();
    write_capacity(65536);
    offer(MODE_CREATE, 0, 1);
    offer(MODE_FIT, 0, 0);
    offer(MODE_FIND, 0, 0);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (find %0d, create %0d, fit %0d, release %0d), %0d responses.",
             sb.mode_seen[MODE_FIND] + sb.mode_seen[MODE_CREATE] + sb.mode_seen[MODE_FIT] +
             sb.mode_seen[MODE_RELEASE], sb.mode_seen[MODE_FIND], sb.mode_seen[MODE_CREATE],
             sb.mode_seen[MODE_FIT], sb.mode_seen[MODE_RELEASE], sb.checked);
    $display("Statuses: ok %0d, no fit %0d, arena full %0d, table full %0d; %0d errors.",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_NO_FIT],
             sb.status_seen[STATUS_ARENA_FULL], sb.status_seen[STATUS_TABLE_FULL], sb.errors);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bfa_pkg.sv
src/bfa_req_if.sv
src/bfa_rsp_if.sv
src/bfa_chunk_mem.sv
src/bfa_align_unit.sv
src/best_fit_arena_allocator_unit.sv
tb/tb.sv
